// File: rtl/albl_pkg.sv
// Shared constants, register codes and types for the ambient light backlight core.
`default_nettype none
package albl_pkg;

   localparam int WINDOW = 5;
   localparam int LUX_W = 16;
   localparam int LEVEL_W = 8;
   localparam int MODE_W = 2;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam logic [CNT_W-1:0] MID_RANK = CNT_W'(WINDOW / 2);

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_DAY_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUSK_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DAY_LEVEL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DUSK_LEVEL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NIGHT_LEVEL = 3'd4;

   localparam logic [LUX_W-1:0] DAY_THRESHOLD_RST = 16'd100;
   localparam logic [LUX_W-1:0] DUSK_THRESHOLD_RST = 16'd10;
   localparam logic [LEVEL_W-1:0] DAY_LEVEL_RST = 8'd255;
   localparam logic [LEVEL_W-1:0] DUSK_LEVEL_RST = 8'd80;
   localparam logic [LEVEL_W-1:0] NIGHT_LEVEL_RST = 8'd20;

   localparam logic [MODE_W-1:0] MODE_DAY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DUSK = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NIGHT = 2'd2;

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   typedef struct packed {
      logic shift;
      logic start;
      logic step;
   } cell_ctl_type;

endpackage
`default_nettype wire

// File: rtl/ambient_light_median_backlight_core.sv
// Top level: sample window cell row, median select, day/dusk/night class and ramp.
// A tick request goes from acceptance straight to the done state; a sample request
// passes the load, rank count and select states, and in the rank count each sample
// circulates once around the row of WINDOW cells. One request is in work at a time;
// a new request is accepted while the previous result still waits in the output
// register. The window is shift ordered (oldest entry drops out), which gives the
// same median as a ring buffer.
`default_nettype none
module ambient_light_median_backlight_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [albl_pkg::REQ_DATA_W-1:0]     req_tdata,  // [15:0] lux
   input  wire logic                                req_tuser,  // [0] action
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] brightness, [9:8] mode, [25:10] median_lux, [26] ramping, [31:27] zero
   output logic [albl_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [albl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [albl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int W = albl_pkg::WINDOW;
   localparam int STEP_W = (W > 2) ? $clog2(W - 1) : 1;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'((W > 1) ? W - 2 : 0);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_COUNT  = 3'd2;
   localparam logic [2:0] ST_SELECT = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]                        state_ff, state_in;
   logic [STEP_W-1:0]                 step_ff, step_in;
   logic                              act_ff;

   logic [albl_pkg::LUX_W-1:0]        day_thr_ff, dusk_thr_ff;
   logic [albl_pkg::LEVEL_W-1:0]      day_lvl_ff, dusk_lvl_ff, night_lvl_ff;

   logic [albl_pkg::MODE_W-1:0]       class_ff, class_in;
   logic [albl_pkg::LEVEL_W-1:0]      now_ff, now_in;
   logic [albl_pkg::LEVEL_W-1:0]      goal_ff, goal_in;
   logic [albl_pkg::LUX_W-1:0]        median_ff;

   logic                              rsp_valid_ff;
   logic [albl_pkg::LEVEL_W-1:0]      rsp_bright_ff;
   logic [albl_pkg::MODE_W-1:0]       rsp_mode_ff;
   logic [albl_pkg::LUX_W-1:0]        rsp_median_ff;
   logic                              rsp_ramp_ff;

   logic                              accept, commit;
   albl_pkg::cell_ctl_type            ctl;
   logic [albl_pkg::LUX_W-1:0]        cell_value [W];
   logic [albl_pkg::LUX_W-1:0]        cell_probe [W];
   logic [W-1:0]                      cell_hit;
   logic [albl_pkg::LUX_W-1:0]        median_sel;
   logic [albl_pkg::MODE_W-1:0]       cls;
   logic [albl_pkg::LEVEL_W-1:0]      cls_level;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign commit     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   assign ctl.shift = accept && (req_tuser == albl_pkg::ACT_SAMPLE);
   assign ctl.start = (state_ff == ST_LOAD);
   assign ctl.step  = (state_ff == ST_COUNT);

   // cell row: samples shift toward higher cells, probes rotate toward lower cells
   for (genvar i = 0; i < W; i++) begin : g_cell
      localparam int NXT = (i + 1) % W;
      localparam int PRV = (i == 0) ? 0 : i - 1;
      albl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .value_prev ((i == 0) ? req_tdata[albl_pkg::LUX_W-1:0] : cell_value[PRV]),
         .probe_next (cell_probe[NXT]),
         .value_ff   (cell_value[i]),
         .probe_ff   (cell_probe[i]),
         .hit        (cell_hit[i])
      );
   end

   // every hitting cell holds the same value, so an OR picks it
   always_comb begin
      median_sel = '0;
      for (int i = 0; i < W; i++) begin
         median_sel = median_sel | (cell_hit[i] ? cell_value[i] : '0);
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_tuser == albl_pkg::ACT_SAMPLE) ? ST_LOAD : ST_DONE;
            end
         end
         ST_LOAD: begin
            step_in  = '0;
            state_in = (W > 1) ? ST_COUNT : ST_SELECT;
         end
         ST_COUNT: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: state_in = ST_DONE;
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (median_ff >= day_thr_ff) begin
         cls = albl_pkg::MODE_DAY;
      end else if (median_ff >= dusk_thr_ff) begin
         cls = albl_pkg::MODE_DUSK;
      end else begin
         cls = albl_pkg::MODE_NIGHT;
      end
      unique case (cls)
         albl_pkg::MODE_DAY:  cls_level = day_lvl_ff;
         albl_pkg::MODE_DUSK: cls_level = dusk_lvl_ff;
         default:             cls_level = night_lvl_ff;
      endcase
   end

   always_comb begin
      class_in = class_ff;
      goal_in  = goal_ff;
      now_in   = now_ff;
      if (act_ff == albl_pkg::ACT_SAMPLE) begin
         if (cls != class_ff) begin
            class_in = cls;
            goal_in  = cls_level;
         end
      end else begin
         priority if (now_ff < goal_ff) begin
            now_in = now_ff + albl_pkg::LEVEL_W'(1);
         end else if (now_ff > goal_ff) begin
            now_in = now_ff - albl_pkg::LEVEL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_thr_ff   <= albl_pkg::DAY_THRESHOLD_RST;
         dusk_thr_ff  <= albl_pkg::DUSK_THRESHOLD_RST;
         day_lvl_ff   <= albl_pkg::DAY_LEVEL_RST;
         dusk_lvl_ff  <= albl_pkg::DUSK_LEVEL_RST;
         night_lvl_ff <= albl_pkg::NIGHT_LEVEL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            albl_pkg::CSR_DAY_THRESHOLD:  day_thr_ff   <= csr_wdata;
            albl_pkg::CSR_DUSK_THRESHOLD: dusk_thr_ff  <= csr_wdata;
            albl_pkg::CSR_DAY_LEVEL:      day_lvl_ff   <= csr_wdata[albl_pkg::LEVEL_W-1:0];
            albl_pkg::CSR_DUSK_LEVEL:     dusk_lvl_ff  <= csr_wdata[albl_pkg::LEVEL_W-1:0];
            albl_pkg::CSR_NIGHT_LEVEL:    night_lvl_ff <= csr_wdata[albl_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_ff  <= albl_pkg::MODE_DAY;
         now_ff    <= albl_pkg::DAY_LEVEL_RST;
         goal_ff   <= albl_pkg::DAY_LEVEL_RST;
         median_ff <= '0;
      end else begin
         if (state_ff == ST_SELECT) begin
            median_ff <= median_sel;
         end
         if (commit) begin
            class_ff <= class_in;
            now_ff   <= now_in;
            goal_ff  <= goal_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_bright_ff <= now_in;
         rsp_mode_ff   <= class_in;
         rsp_median_ff <= median_ff;
         rsp_ramp_ff   <= (now_in != goal_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ramp_ff, rsp_median_ff, rsp_mode_ff, rsp_bright_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUNT) |-> (step_ff <= STEP_LAST))
      else $error("rank count ran past the window");

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_mode_ff != 2'd3))
      else $error("illegal light class in result");

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_bright_ff == now_ff) && (rsp_mode_ff == class_ff)
                        && (rsp_ramp_ff == (now_ff != goal_ff))))
      else $error("result register disagrees with level state");

   a_tick_no_window: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == albl_pkg::ACT_TICK)) |=> (state_ff == ST_DONE))
      else $error("tick request entered the median path");
`endif

endmodule
`default_nettype wire

// File: rtl/albl_cell.sv
// One window cell: holds a sample, a circulating probe and its rank counters.
`default_nettype none
module albl_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire albl_pkg::cell_ctl_type     ctl,
   input  wire logic [albl_pkg::LUX_W-1:0] value_prev,
   input  wire logic [albl_pkg::LUX_W-1:0] probe_next,
   output logic [albl_pkg::LUX_W-1:0]      value_ff,
   output logic [albl_pkg::LUX_W-1:0]      probe_ff,
   output logic                            hit
);

   logic [albl_pkg::CNT_W-1:0] lt_ff;
   logic [albl_pkg::CNT_W-1:0] le_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else if (ctl.shift) begin
         value_ff <= value_prev;
      end
   end

   // lt counts smaller entries, le counts smaller-or-equal ones including itself
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         probe_ff <= value_ff;
         lt_ff    <= '0;
         le_ff    <= albl_pkg::CNT_W'(1);
      end else if (ctl.step) begin
         probe_ff <= probe_next;
         lt_ff    <= lt_ff + albl_pkg::CNT_W'(probe_next < value_ff);
         le_ff    <= le_ff + albl_pkg::CNT_W'(probe_next <= value_ff);
      end
   end

   assign hit = (lt_ff <= albl_pkg::MID_RANK) && (albl_pkg::MID_RANK < le_ff);

endmodule
`default_nettype wire
